// ===== src/dfpc_pkg.sv =====
// shared types and constants for the delimited frame parser with checksum
// no dependencies; imported by every other file of the block
`default_nettype none

package dfpc_pkg;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int ID_W      = 16;
   localparam int CSUM_W    = 10;
   localparam int SUM_W     = 7;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   // byte queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // saturation limits and checksum modulus
   localparam logic [ID_W-1:0]   ID_MAX   = '1;
   localparam logic [CSUM_W-1:0] CSUM_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MOD  = 7'd100;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_DELIM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_OPEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_CLOSE = 2'd2;

   // control register reset values
   localparam logic [BYTE_W-1:0] FIELD_DELIM_RST   = 8'd124;
   localparam logic [BYTE_W-1:0] PAYLOAD_OPEN_RST  = 8'd62;
   localparam logic [BYTE_W-1:0] PAYLOAD_CLOSE_RST = 8'd60;

   // character classes
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // summary status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EARLY_EOL = 2'd2;

   // classified input byte as queued for the back end
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              end_of_line;
      logic              is_field_delim;
      logic              is_payload_open;
      logic              is_payload_close;
      logic              is_digit;
      logic              is_space;
   } entry_type;

   // one result word
   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [ID_W-1:0]     message_id;
      logic [CSUM_W-1:0]   checksum_received;
      logic [SUM_W-1:0]    checksum_computed;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== src/dfpc_if.sv =====
// channel interfaces: input bytes, result words and control register writes
// depends on dfpc_pkg for widths
`default_nettype none

interface dfpc_req_if import dfpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              end_of_line;

   modport source (output valid, output rx_byte, output end_of_line, input ready);
   modport sink (input valid, input rx_byte, input end_of_line, output ready);
endinterface

interface dfpc_rsp_if import dfpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [ID_W-1:0]     message_id;
   logic [CSUM_W-1:0]   checksum_received;
   logic [SUM_W-1:0]    checksum_computed;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output kind, output payload_byte, output message_id,
                   output checksum_received, output checksum_computed, output status,
                   output last, input ready);
   modport sink (input valid, input kind, input payload_byte, input message_id,
                 input checksum_received, input checksum_computed, input status,
                 input last, output ready);
endinterface

interface dfpc_csr_if import dfpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/dfpc_front.sv =====
// front end: control registers, byte acceptance and classification
// depends on dfpc_pkg and the channel interfaces in dfpc_if
`default_nettype none

module dfpc_front import dfpc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   dfpc_req_if.sink    req_ch,
   dfpc_csr_if.sink    csr_ch,
   input  wire logic   fifo_full,
   output logic        push,
   output entry_type   push_entry
);

   logic [BYTE_W-1:0] field_delim_ff, field_delim_in;
   logic [BYTE_W-1:0] payload_open_ff, payload_open_in;
   logic [BYTE_W-1:0] payload_close_ff, payload_close_in;
   logic [BYTE_W-1:0] b;

   // control register writes, always ready
   assign csr_ch.ready = 1'b1;

   always_comb begin
      field_delim_in   = field_delim_ff;
      payload_open_in  = payload_open_ff;
      payload_close_in = payload_close_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FIELD_DELIM:   field_delim_in   = csr_ch.data;
            CSR_PAYLOAD_OPEN:  payload_open_in  = csr_ch.data;
            CSR_PAYLOAD_CLOSE: payload_close_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_delim_ff   <= FIELD_DELIM_RST;
         payload_open_ff  <= PAYLOAD_OPEN_RST;
         payload_close_ff <= PAYLOAD_CLOSE_RST;
      end else begin
         field_delim_ff   <= field_delim_in;
         payload_open_ff  <= payload_open_in;
         payload_close_ff <= payload_close_in;
      end
   end

   // take a word whenever the queue has room
   assign req_ch.ready = !fifo_full;
   assign push        = req_ch.valid && !fifo_full;

   // classify the byte against the delimiters and character classes
   assign b = req_ch.rx_byte;

   always_comb begin
      push_entry.rx_byte          = b;
      push_entry.end_of_line      = req_ch.end_of_line;
      push_entry.is_field_delim   = (b == field_delim_ff);
      push_entry.is_payload_open  = (b == payload_open_ff);
      push_entry.is_payload_close = (b == payload_close_ff);
      push_entry.is_digit         = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      push_entry.is_space         = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   end

endmodule

`default_nettype wire

// ===== src/dfpc_fifo.sv =====
// short queue of classified bytes between front and back end
// depends on dfpc_pkg for the entry type and depth
`default_nettype none

module dfpc_fifo import dfpc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output logic            full,
   output logic            empty,
   output entry_type       head
);

   entry_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/dfpc_back.sv =====
// back end: frame state machine, decimal fields, checksum and result register
// depends on dfpc_pkg and the result interface in dfpc_if
`default_nettype none

module dfpc_back import dfpc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire entry_type  head,
   input  wire logic       empty,
   output logic            pop,
   dfpc_rsp_if.source      rsp_ch
);

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_ID,
      PH_SEEK,
      PH_PAYLOAD,
      PH_CSUM,
      PH_DONE
   } phase_type;

   localparam int ID_WIDE_W   = ID_W + 4;
   localparam int CSUM_WIDE_W = CSUM_W + 4;
   localparam int ADD_W       = BYTE_W + 1;

   phase_type           phase_ff, phase_in, step_phase;
   logic [ID_W-1:0]     id_acc_ff, id_acc_in, step_id;
   logic                id_stop_ff, id_stop_in, step_id_stop;
   logic [CSUM_W-1:0]   csum_acc_ff, csum_acc_in, step_csum;
   logic                csum_stop_ff, csum_stop_in, step_csum_stop;
   logic [SUM_W-1:0]    sum_ff, sum_in, step_sum;
   logic                started_ff, started_in, step_started;
   logic                split_ff, split_in;
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        out_ff, out_in;

   logic [ID_WIDE_W-1:0]   id_wide;
   logic [CSUM_WIDE_W-1:0] csum_wide;
   logic [ID_W-1:0]        id_sat;
   logic [CSUM_W-1:0]      csum_sat;
   logic [ADD_W-1:0]       sum_raw;
   logic [SUM_W-1:0]       sum_add;
   logic                   take;
   logic                   emit_pl, emit_csum, eol_summary;
   logic                   out_free, load, apply, clear;
   rsp_word_type           pl_word, sum_word, split_word;

   // saturating decimal digit append
   assign id_wide = ID_WIDE_W'({id_acc_ff, 3'b000}) + ID_WIDE_W'({id_acc_ff, 1'b0})
                  + ID_WIDE_W'(head.rx_byte[3:0]);
   assign id_sat  = (id_wide > ID_WIDE_W'(ID_MAX)) ? ID_MAX : id_wide[ID_W-1:0];
   assign csum_wide = CSUM_WIDE_W'({csum_acc_ff, 3'b000}) + CSUM_WIDE_W'({csum_acc_ff, 1'b0})
                    + CSUM_WIDE_W'(head.rx_byte[3:0]);
   assign csum_sat  = (csum_wide > CSUM_WIDE_W'(CSUM_MAX)) ? CSUM_MAX
                                                           : csum_wide[CSUM_W-1:0];

   // running sum mod 100, sum below 100 plus a byte stays below 400
   assign sum_raw = ADD_W'(sum_ff) + ADD_W'(head.rx_byte);
   always_comb begin
      if (sum_raw >= ADD_W'(3 * 100)) begin
         sum_add = SUM_W'(sum_raw - ADD_W'(3 * 100));
      end else if (sum_raw >= ADD_W'(2 * 100)) begin
         sum_add = SUM_W'(sum_raw - ADD_W'(2 * 100));
      end else if (sum_raw >= ADD_W'(SUM_MOD)) begin
         sum_add = SUM_W'(sum_raw - ADD_W'(SUM_MOD));
      end else begin
         sum_add = SUM_W'(sum_raw);
      end
   end

   // leading whitespace is skipped until the field has started
   assign take = started_ff || !head.is_space;

   // per-byte state step, before the end-of-line clear
   always_comb begin
      step_phase     = phase_ff;
      step_id        = id_acc_ff;
      step_id_stop   = id_stop_ff;
      step_csum      = csum_acc_ff;
      step_csum_stop = csum_stop_ff;
      step_sum       = sum_ff;
      step_started   = started_ff;
      emit_pl        = 1'b0;
      emit_csum      = 1'b0;
      case (phase_ff)
         PH_WAIT: begin
            if (head.is_field_delim) begin
               step_phase   = PH_ID;
               step_started = 1'b0;
            end
         end
         PH_ID: begin
            if (head.is_field_delim) begin
               step_phase = PH_SEEK;
            end else if (!id_stop_ff && take) begin
               step_started = 1'b1;
               if (head.is_digit) begin
                  step_id = id_sat;
               end else begin
                  step_id_stop = 1'b1;
               end
            end
         end
         PH_SEEK: begin
            if (head.is_payload_open) begin
               step_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (head.is_payload_close) begin
               step_phase   = PH_CSUM;
               step_started = 1'b0;
            end else begin
               step_sum = sum_add;
               emit_pl  = 1'b1;
            end
         end
         PH_CSUM: begin
            if (head.is_field_delim) begin
               emit_csum  = 1'b1;
               step_phase = PH_DONE;
            end else if (!csum_stop_ff && take) begin
               step_started = 1'b1;
               if (head.is_digit) begin
                  step_csum = csum_sat;
               end else begin
                  step_csum_stop = 1'b1;
               end
            end
         end
         default: begin
            step_phase = PH_DONE;
         end
      endcase
   end

   assign eol_summary = head.end_of_line && (step_phase != PH_DONE);

   // candidate result words
   always_comb begin
      pl_word              = '0;
      pl_word.kind         = KIND_PAYLOAD;
      pl_word.payload_byte = head.rx_byte;
      pl_word.last         = !head.end_of_line;

      sum_word                   = '0;
      sum_word.kind              = KIND_SUMMARY;
      sum_word.message_id        = step_id;
      sum_word.checksum_received = step_csum;
      sum_word.checksum_computed = step_sum;
      sum_word.last              = 1'b1;
      if (emit_csum) begin
         sum_word.status = (step_csum == CSUM_W'(step_sum)) ? STATUS_OK : STATUS_MISMATCH;
      end else begin
         sum_word.status = STATUS_EARLY_EOL;
      end

      split_word                   = '0;
      split_word.kind              = KIND_SUMMARY;
      split_word.message_id        = id_acc_ff;
      split_word.checksum_received = csum_acc_ff;
      split_word.checksum_computed = sum_ff;
      split_word.status            = STATUS_EARLY_EOL;
      split_word.last              = 1'b1;
   end

   // issue control: a payload byte that ends the line takes two result slots
   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      load     = 1'b0;
      out_in   = out_ff;
      pop      = 1'b0;
      apply    = 1'b0;
      clear    = 1'b0;
      split_in = split_ff;
      if (split_ff) begin
         if (out_free) begin
            load     = 1'b1;
            out_in   = split_word;
            pop      = 1'b1;
            clear    = 1'b1;
            split_in = 1'b0;
         end
      end else if (!empty) begin
         if (emit_pl && head.end_of_line) begin
            if (out_free) begin
               load     = 1'b1;
               out_in   = pl_word;
               apply    = 1'b1;
               split_in = 1'b1;
            end
         end else if (emit_pl || emit_csum || eol_summary) begin
            if (out_free) begin
               load   = 1'b1;
               out_in = emit_pl ? pl_word : sum_word;
               apply  = 1'b1;
               clear  = head.end_of_line;
               pop    = 1'b1;
            end
         end else begin
            apply = 1'b1;
            clear = head.end_of_line;
            pop   = 1'b1;
         end
      end
   end

   // next state selection
   always_comb begin
      phase_in     = phase_ff;
      id_acc_in    = id_acc_ff;
      id_stop_in   = id_stop_ff;
      csum_acc_in  = csum_acc_ff;
      csum_stop_in = csum_stop_ff;
      sum_in       = sum_ff;
      started_in   = started_ff;
      if (clear) begin
         phase_in     = PH_WAIT;
         id_acc_in    = '0;
         id_stop_in   = 1'b0;
         csum_acc_in  = '0;
         csum_stop_in = 1'b0;
         sum_in       = '0;
         started_in   = 1'b0;
      end else if (apply) begin
         phase_in     = step_phase;
         id_acc_in    = step_id;
         id_stop_in   = step_id_stop;
         csum_acc_in  = step_csum;
         csum_stop_in = step_csum_stop;
         sum_in       = step_sum;
         started_in   = step_started;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         id_acc_ff    <= '0;
         id_stop_ff   <= 1'b0;
         csum_acc_ff  <= '0;
         csum_stop_ff <= 1'b0;
         sum_ff       <= '0;
         started_ff   <= 1'b0;
         split_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         id_acc_ff    <= id_acc_in;
         id_stop_ff   <= id_stop_in;
         csum_acc_ff  <= csum_acc_in;
         csum_stop_ff <= csum_stop_in;
         sum_ff       <= sum_in;
         started_ff   <= started_in;
         split_ff     <= split_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   // result channel
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.kind              = out_ff.kind;
   assign rsp_ch.payload_byte      = out_ff.payload_byte;
   assign rsp_ch.message_id        = out_ff.message_id;
   assign rsp_ch.checksum_received = out_ff.checksum_received;
   assign rsp_ch.checksum_computed = out_ff.checksum_computed;
   assign rsp_ch.status            = out_ff.status;
   assign rsp_ch.last              = out_ff.last;

   // running checksum stays reduced
   a_sum_reduced: assert property (@(posedge clock) disable iff (reset)
      sum_ff < SUM_MOD)
      else $error("running sum not reduced mod 100");

   // the pending summary only follows a payload byte
   a_split_phase: assert property (@(posedge clock) disable iff (reset)
      split_ff |-> (phase_ff == PH_PAYLOAD))
      else $error("pending summary outside payload phase");

   // the first half of a split item is a non-final payload word
   a_split_first: assert property (@(posedge clock) disable iff (reset)
      $rose(split_ff) |-> (out_valid_ff && (out_ff.kind == KIND_PAYLOAD) && !out_ff.last))
      else $error("split item did not issue a payload word first");

   // retiring an end-of-line byte restarts the frame search
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head.end_of_line) |=> ((phase_ff == PH_WAIT) && !split_ff && (sum_ff == '0)))
      else $error("state not cleared after end of line");

endmodule

`default_nettype wire

// ===== src/delimited_frame_parser_checksum.sv =====
// The parser takes a text line |id|>payload<checksum| byte by byte and returns one word
// per payload byte plus one summary word per line (id, received and computed checksum,
// status). A byte is accepted in the cycle it is offered whenever the four-entry byte
// queue has room; the back end retires one queued byte per cycle while results are
// taken, and results leave through a single output register, so the sustained rate is
// one byte per cycle. The one exception is a payload byte that also ends the line: it
// yields two words and retires with the second. Delimiters are set through the control
// register port, which should only be written while the parser is idle.
// top level; depends on dfpc_pkg, dfpc_if, dfpc_front, dfpc_fifo and dfpc_back
`default_nettype none

module delimited_frame_parser_checksum import dfpc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   dfpc_req_if.sink    req_ch,
   dfpc_rsp_if.source  rsp_ch,
   dfpc_csr_if.sink    csr_ch
);

   logic      fifo_full;
   logic      fifo_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   // accept and classify
   dfpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // byte queue
   dfpc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (fifo_full),
      .empty      (fifo_empty),
      .head       (head)
   );

   // frame parsing and results
   dfpc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (fifo_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire
